// ===== sv/scaled_glyph_text_rasterizer_assert.svh =====
// Assertion macros for the glyph rasterizer.
`ifndef SCALED_GLYPH_TEXT_RASTERIZER_ASSERT_SVH
`define SCALED_GLYPH_TEXT_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SGTR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgtr assertion failed");

// Next-cycle implication, checked outside reset.
`define SGTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgtr assertion failed");

`else

`define SGTR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SGTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/sgtr_pkg.sv =====
package sgtr_pkg;

  localparam int unsigned FONT_ROWS = 7;
  localparam int unsigned FONT_COLS = 5;
  localparam int unsigned FONT_DOTS = FONT_ROWS * FONT_COLS;

  localparam logic [3:0] MAX_CLIPPED_CHARS = 4'd15;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_SCALE        = 3'd2;
  localparam logic [2:0] REG_INK          = 3'd3;
  localparam logic [2:0] REG_LIMIT_ENABLE = 3'd4;
  localparam logic [2:0] REG_MAX_WIDTH    = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN
  } sgtr_state_t;

  typedef logic [FONT_DOTS-1:0] glyph_t;

  // Font ROM. Bit i of the result is dot i in row-major order, so bit 0 is the
  // top-left dot. Codes that are not in the font return a blank glyph.
  function automatic glyph_t font_glyph(input logic [7:0] code);
    glyph_t rows;
    glyph_t g;
    case (code)
      "A": rows = {5'b01110, 5'b10001, 5'b10001, 5'b11111, 5'b10001, 5'b10001, 5'b10001};
      "B": rows = {5'b11110, 5'b10001, 5'b10001, 5'b11110, 5'b10001, 5'b10001, 5'b11110};
      "C": rows = {5'b01111, 5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b01111};
      "D": rows = {5'b11110, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b11110};
      "E": rows = {5'b11111, 5'b10000, 5'b10000, 5'b11110, 5'b10000, 5'b10000, 5'b11111};
      "F": rows = {5'b11111, 5'b10000, 5'b10000, 5'b11110, 5'b10000, 5'b10000, 5'b10000};
      "G": rows = {5'b01111, 5'b10000, 5'b10000, 5'b10111, 5'b10001, 5'b10001, 5'b01110};
      "H": rows = {5'b10001, 5'b10001, 5'b10001, 5'b11111, 5'b10001, 5'b10001, 5'b10001};
      "I": rows = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b11111};
      "J": rows = {5'b00111, 5'b00010, 5'b00010, 5'b00010, 5'b10010, 5'b10010, 5'b01100};
      "K": rows = {5'b10001, 5'b10010, 5'b10100, 5'b11000, 5'b10100, 5'b10010, 5'b10001};
      "L": rows = {5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b11111};
      "M": rows = {5'b10001, 5'b11011, 5'b10101, 5'b10101, 5'b10001, 5'b10001, 5'b10001};
      "N": rows = {5'b10001, 5'b11001, 5'b10101, 5'b10011, 5'b10001, 5'b10001, 5'b10001};
      "O": rows = {5'b01110, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b01110};
      "P": rows = {5'b11110, 5'b10001, 5'b10001, 5'b11110, 5'b10000, 5'b10000, 5'b10000};
      "Q": rows = {5'b01110, 5'b10001, 5'b10001, 5'b10001, 5'b10101, 5'b10010, 5'b01101};
      "R": rows = {5'b11110, 5'b10001, 5'b10001, 5'b11110, 5'b10100, 5'b10010, 5'b10001};
      "S": rows = {5'b01111, 5'b10000, 5'b10000, 5'b01110, 5'b00001, 5'b00001, 5'b11110};
      "T": rows = {5'b11111, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b00100};
      "U": rows = {5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b01110};
      "V": rows = {5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b10001, 5'b01010, 5'b00100};
      "W": rows = {5'b10001, 5'b10001, 5'b10001, 5'b10101, 5'b10101, 5'b10101, 5'b01010};
      "X": rows = {5'b10001, 5'b10001, 5'b01010, 5'b00100, 5'b01010, 5'b10001, 5'b10001};
      "Y": rows = {5'b10001, 5'b10001, 5'b01010, 5'b00100, 5'b00100, 5'b00100, 5'b00100};
      "Z": rows = {5'b11111, 5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b10000, 5'b11111};
      "0": rows = {5'b01110, 5'b10001, 5'b10011, 5'b10101, 5'b11001, 5'b10001, 5'b01110};
      "1": rows = {5'b00100, 5'b01100, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b01110};
      "2": rows = {5'b01110, 5'b10001, 5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b11111};
      "3": rows = {5'b11110, 5'b00001, 5'b00001, 5'b01110, 5'b00001, 5'b00001, 5'b11110};
      "4": rows = {5'b00010, 5'b00110, 5'b01010, 5'b10010, 5'b11111, 5'b00010, 5'b00010};
      "5": rows = {5'b11111, 5'b10000, 5'b10000, 5'b11110, 5'b00001, 5'b00001, 5'b11110};
      "6": rows = {5'b00110, 5'b01000, 5'b10000, 5'b11110, 5'b10001, 5'b10001, 5'b01110};
      "7": rows = {5'b11111, 5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b01000, 5'b01000};
      "8": rows = {5'b01110, 5'b10001, 5'b10001, 5'b01110, 5'b10001, 5'b10001, 5'b01110};
      "9": rows = {5'b01110, 5'b10001, 5'b10001, 5'b01111, 5'b00001, 5'b00010, 5'b01100};
      "-": rows = {5'b00000, 5'b00000, 5'b00000, 5'b11111, 5'b00000, 5'b00000, 5'b00000};
      "/": rows = {5'b00001, 5'b00010, 5'b00010, 5'b00100, 5'b01000, 5'b01000, 5'b10000};
      ">": rows = {5'b10000, 5'b01000, 5'b00100, 5'b00010, 5'b00100, 5'b01000, 5'b10000};
      "a": rows = {5'b00000, 5'b00000, 5'b01110, 5'b00001, 5'b01111, 5'b10001, 5'b01111};
      "b": rows = {5'b10000, 5'b10000, 5'b10110, 5'b11001, 5'b10001, 5'b11001, 5'b10110};
      "c": rows = {5'b00000, 5'b00000, 5'b01111, 5'b10000, 5'b10000, 5'b10000, 5'b01111};
      "d": rows = {5'b00001, 5'b00001, 5'b01101, 5'b10011, 5'b10001, 5'b10011, 5'b01101};
      "e": rows = {5'b00000, 5'b00000, 5'b01110, 5'b10001, 5'b11111, 5'b10000, 5'b01110};
      "f": rows = {5'b00110, 5'b01001, 5'b01000, 5'b11100, 5'b01000, 5'b01000, 5'b01000};
      "g": rows = {5'b00000, 5'b00000, 5'b01101, 5'b10011, 5'b01111, 5'b00001, 5'b01110};
      "h": rows = {5'b10000, 5'b10000, 5'b10110, 5'b11001, 5'b10001, 5'b10001, 5'b10001};
      "i": rows = {5'b00100, 5'b00000, 5'b01100, 5'b00100, 5'b00100, 5'b00100, 5'b01110};
      "j": rows = {5'b00010, 5'b00000, 5'b00110, 5'b00010, 5'b00010, 5'b10010, 5'b01100};
      "k": rows = {5'b10000, 5'b10010, 5'b10100, 5'b11000, 5'b10100, 5'b10010, 5'b10001};
      "l": rows = {5'b01100, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b00100, 5'b01110};
      "m": rows = {5'b00000, 5'b00000, 5'b11010, 5'b10101, 5'b10101, 5'b10101, 5'b10101};
      "n": rows = {5'b00000, 5'b00000, 5'b10110, 5'b11001, 5'b10001, 5'b10001, 5'b10001};
      "o": rows = {5'b00000, 5'b00000, 5'b01110, 5'b10001, 5'b10001, 5'b10001, 5'b01110};
      "p": rows = {5'b00000, 5'b00000, 5'b11110, 5'b10001, 5'b11110, 5'b10000, 5'b10000};
      "q": rows = {5'b00000, 5'b00000, 5'b01101, 5'b10011, 5'b01111, 5'b00001, 5'b00001};
      "r": rows = {5'b00000, 5'b00000, 5'b10110, 5'b11001, 5'b10000, 5'b10000, 5'b10000};
      "s": rows = {5'b00000, 5'b00000, 5'b01111, 5'b10000, 5'b01110, 5'b00001, 5'b11110};
      "t": rows = {5'b00100, 5'b00100, 5'b11111, 5'b00100, 5'b00100, 5'b00101, 5'b00010};
      "u": rows = {5'b00000, 5'b00000, 5'b10001, 5'b10001, 5'b10001, 5'b10011, 5'b01101};
      "v": rows = {5'b00000, 5'b00000, 5'b10001, 5'b10001, 5'b10001, 5'b01010, 5'b00100};
      "w": rows = {5'b00000, 5'b00000, 5'b10001, 5'b10001, 5'b10101, 5'b10101, 5'b01010};
      "x": rows = {5'b00000, 5'b00000, 5'b10001, 5'b01010, 5'b00100, 5'b01010, 5'b10001};
      "y": rows = {5'b00000, 5'b00000, 5'b10001, 5'b10001, 5'b01111, 5'b00001, 5'b01110};
      "z": rows = {5'b00000, 5'b00000, 5'b11111, 5'b00010, 5'b00100, 5'b01000, 5'b11111};
      default: rows = '0;
    endcase
    // The literals above read left to right, top to bottom; flip them so that
    // the first dot lands in bit 0.
    for (int i = 0; i < FONT_DOTS; i++) begin
      g[i] = rows[FONT_DOTS-1-i];
    end
    return g;
  endfunction

endpackage

// ===== sv/scaled_glyph_text_rasterizer.sv =====
// The first square of a character is presented from the output register after the
// item is taken, with ST_LOOK and the scan over its unlit leading dots in between.
// The block takes a new character only in ST_IDLE, once the last one is done.
// The glyph scan steps one font dot per cycle and holds while a lit dot stalls.
// Reset is synchronous, active low; the registers in the reset branches return to
// their listed defaults, but scan position, code and output data are not reset.
`include "scaled_glyph_text_rasterizer_assert.svh"

module scaled_glyph_text_rasterizer import sgtr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_first_char,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_dot_x,
  output logic [11:0] out_dot_y,
  output logic [3:0]  out_dot_size,
  output logic [3:0]  out_dot_ink,
  output logic        out_last_dot,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [10:0] origin_x_r;
  logic [10:0] origin_y_r;
  logic [3:0]  scale_r;
  logic [3:0]  ink_r;
  logic        limit_enable_r;
  logic [11:0] max_width_r;

  // String state.
  logic [15:0] cursor_x_r,       cursor_x_nxt;
  logic [11:0] used_width_r,     used_width_nxt;
  logic [3:0]  chars_taken_r,    chars_taken_nxt;
  logic        string_stopped_r, string_stopped_nxt;

  sgtr_state_t state_r, state_nxt;

  // Scan registers.
  logic [7:0]  code_r;
  glyph_t      glyph_r,  glyph_nxt;
  logic [2:0]  col_r,    col_nxt;
  logic [5:0]  xoff_r,   xoff_nxt;
  logic [11:0] ypos_r,   ypos_nxt;
  logic [6:0]  adv_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] dot_x_r;
  logic [11:0] dot_y_r;
  logic [3:0]  dot_size_r;
  logic [3:0]  dot_ink_r;
  logic        last_dot_r;

  logic        in_accept;
  logic        cfg_write;
  logic [2:0]  reg_idx;
  logic        scan_step;
  logic        dot_load;
  logic        clip;
  logic [6:0]  adv;
  logic [12:0] width_sum;
  logic [16:0] cursor_sum;
  logic [16:0] dot_x_sum;
  logic [15:0] dot_x_sat;

  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[4:2];
  assign pready    = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      scale_r        <= 4'd1;
      ink_r          <= '0;
      limit_enable_r <= 1'b0;
      max_width_r    <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ORIGIN_X:     origin_x_r     <= pwdata[10:0];
        REG_ORIGIN_Y:     origin_y_r     <= pwdata[10:0];
        REG_SCALE:        scale_r        <= pwdata[3:0];
        REG_INK:          ink_r          <= pwdata[3:0];
        REG_LIMIT_ENABLE: limit_enable_r <= pwdata[0];
        REG_MAX_WIDTH:    max_width_r    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:     prdata = {21'd0, origin_x_r};
      REG_ORIGIN_Y:     prdata = {21'd0, origin_y_r};
      REG_SCALE:        prdata = {28'd0, scale_r};
      REG_INK:          prdata = {28'd0, ink_r};
      REG_LIMIT_ENABLE: prdata = {31'd0, limit_enable_r};
      REG_MAX_WIDTH:    prdata = {20'd0, max_width_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = clip ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (glyph_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    scan_step = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_LOOK: ;
      // A lit dot moves on only when the output register is free or drains.
      ST_SCAN: scan_step = (glyph_r != '0) && !(glyph_r[0] && out_valid_r && out_stall);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  // Advance is 4 * scale for a space and 6 * scale for everything else.
  assign adv = {1'b0, scale_r, 2'b00} +
               ((code_r == CHAR_SPACE) ? 7'd0 : {2'b00, scale_r, 1'b0});
  assign width_sum = {1'b0, used_width_r} + {6'd0, adv};
  assign clip = limit_enable_r &&
                (string_stopped_r || (chars_taken_r >= MAX_CLIPPED_CHARS) ||
                 (width_sum > {1'b0, max_width_r}));

  assign cursor_sum = {1'b0, cursor_x_r} + {10'd0, adv_r};
  assign dot_x_sum  = {1'b0, cursor_x_r} + {11'd0, xoff_r};
  assign dot_x_sat  = dot_x_sum[16] ? 16'hFFFF : dot_x_sum[15:0];
  assign dot_load   = scan_step && glyph_r[0];

  always_comb begin
    cursor_x_nxt       = cursor_x_r;
    used_width_nxt     = used_width_r;
    chars_taken_nxt    = chars_taken_r;
    string_stopped_nxt = string_stopped_r;
    glyph_nxt          = glyph_r;
    col_nxt            = col_r;
    xoff_nxt           = xoff_r;
    ypos_nxt           = ypos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_first_char) begin
          cursor_x_nxt       = {5'd0, origin_x_r};
          used_width_nxt     = '0;
          chars_taken_nxt    = '0;
          string_stopped_nxt = 1'b0;
        end
      end
      ST_LOOK: begin
        if (clip) begin
          string_stopped_nxt = 1'b1;
          glyph_nxt          = '0;
        end else begin
          if (limit_enable_r) begin
            if (chars_taken_r != 4'hF) begin
              chars_taken_nxt = chars_taken_r + 4'd1;
            end
            used_width_nxt = width_sum[11:0];
          end
          glyph_nxt = font_glyph(code_r);
        end
        col_nxt  = '0;
        xoff_nxt = '0;
        ypos_nxt = {1'b0, origin_y_r};
      end
      ST_SCAN: begin
        if (glyph_r == '0) begin
          cursor_x_nxt = cursor_sum[16] ? 16'hFFFF : cursor_sum[15:0];
        end else if (scan_step) begin
          glyph_nxt = glyph_r >> 1;
          if (col_r == 3'(FONT_COLS - 1)) begin
            col_nxt  = '0;
            xoff_nxt = '0;
            ypos_nxt = ypos_r + {8'd0, scale_r};
          end else begin
            col_nxt  = col_r + 3'd1;
            xoff_nxt = xoff_r + {2'd0, scale_r};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = dot_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      cursor_x_r       <= '0;
      used_width_r     <= '0;
      chars_taken_r    <= '0;
      string_stopped_r <= 1'b0;
      glyph_r          <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      cursor_x_r       <= cursor_x_nxt;
      used_width_r     <= used_width_nxt;
      chars_taken_r    <= chars_taken_nxt;
      string_stopped_r <= string_stopped_nxt;
      glyph_r          <= glyph_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    xoff_r <= xoff_nxt;
    ypos_r <= ypos_nxt;
    if (in_accept) begin
      code_r <= in_char_code;
    end
    if (state_r == ST_LOOK) begin
      adv_r <= adv;
    end
    if (dot_load) begin
      dot_x_r    <= dot_x_sat;
      dot_y_r    <= ypos_r;
      dot_size_r <= scale_r;
      dot_ink_r  <= ink_r;
      last_dot_r <= (glyph_r[FONT_DOTS-1:1] == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dot_x    = dot_x_r;
  assign out_dot_y    = dot_y_r;
  assign out_dot_size = dot_size_r;
  assign out_dot_ink  = dot_ink_r;
  assign out_last_dot = last_dot_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SGTR_ASSERT_NEXT(a_last_empties_glyph, clk, rst_n, dot_load && glyph_r[FONT_DOTS-1:1] == '0, glyph_r == '0)
  `SGTR_ASSERT_NEXT(a_blocked_dot_holds, clk, rst_n, state_r == ST_SCAN && glyph_r[0] && out_valid_r && out_stall, $stable(glyph_r) && out_valid_r)
  `SGTR_ASSERT_NEXT(a_scan_done_idle, clk, rst_n, state_r == ST_SCAN && glyph_r == '0, state_r == ST_IDLE)
  `SGTR_ASSERT_NOW(a_no_take_busy, clk, rst_n, in_accept, state_r == ST_IDLE)

endmodule
